### sv/dpd_pkg.sv
`default_nettype none

package dpd_pkg;

  // Image geometry
  localparam int MAX_COLS = 1024;

  // Field widths
  localparam int COL_W    = 10;
  localparam int ROW_W    = 10;
  localparam int DEPTH_W  = 16;
  localparam int COLOR_W  = 8;
  localparam int COORD_W  = 32;
  localparam int CENTER_W = 16;
  localparam int INV_W    = 24;
  localparam int SCALE_W  = 24;
  localparam int MAXD_W   = 16;

  // Fixed-point layout
  localparam int FRAC_PIX    = 6;                            // Q.6 pixel offsets
  localparam int OFS_W       = CENTER_W + 1;                 // signed pixel offset
  localparam int SCALE_FRAC  = 16;                           // Q8.16 depth scale
  localparam int RAWPROD_W   = DEPTH_W + SCALE_W;            // raw * scale
  localparam int DIST_W      = RAWPROD_W - SCALE_FRAC;       // distance before cutoff
  localparam int OZ_W        = OFS_W + DEPTH_W + 1;          // offset * z
  localparam int LAT_W       = OZ_W + INV_W + 1;             // offset * z * inv
  localparam int ROUND_SHIFT = 26;                           // Q.30 -> Q.4

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X    = 3'd0,
    REG_CENTER_Y    = 3'd1,
    REG_INV_FOCAL_X = 3'd2,
    REG_INV_FOCAL_Y = 3'd3,
    REG_MM_PER_UNIT = 3'd4,
    REG_MAX_DEPTH   = 3'd5
  } cfg_reg_t;

  // Register reset values
  localparam logic [CENTER_W-1:0] CENTER_X_RST    = 16'd20128;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST    = 16'd14804;
  localparam logic [INV_W-1:0]    INV_FOCAL_X_RST = 24'd27079;
  localparam logic [INV_W-1:0]    INV_FOCAL_Y_RST = 24'd27091;
  localparam logic [SCALE_W-1:0]  MM_PER_UNIT_RST = 24'd65536;
  localparam logic [MAXD_W-1:0]   MAX_DEPTH_RST   = 16'd1000;

  typedef struct packed {
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [INV_W-1:0]    inv_focal_x;
    logic [INV_W-1:0]    inv_focal_y;
    logic [SCALE_W-1:0]  mm_per_unit;
    logic [MAXD_W-1:0]   max_depth;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]   pixel_col;
    logic [ROW_W-1:0]   pixel_row;
    logic [DEPTH_W-1:0] depth_raw;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
    logic               frame_end_in;
  } pixel_t;

  typedef struct packed {
    logic                      point_valid;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [DEPTH_W-1:0]        point_z;
    logic [COLOR_W-1:0]        red_out;
    logic [COLOR_W-1:0]        green_out;
    logic [COLOR_W-1:0]        blue_out;
    logic                      frame_end_out;
  } point_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

### sv/dpd_pix_if.sv
`default_nettype none

interface dpd_pix_if import dpd_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/dpd_pt_if.sv
`default_nettype none

interface dpd_pt_if import dpd_pkg::*; ();
  logic   valid;
  logic   ready;
  point_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/dpd_cfg_if.sv
`default_nettype none

interface dpd_cfg_if import dpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

### sv/dpd_cfg_regs.sv
`default_nettype none

module dpd_cfg_regs import dpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  dpd_cfg_if.sink   cfg,
  output cfg_t      regs
);

  // Every write is accepted; ready is tied high
  assign cfg.ready = 1'b1;

  // Register file; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.center_x    <= CENTER_X_RST;
      regs.center_y    <= CENTER_Y_RST;
      regs.inv_focal_x <= INV_FOCAL_X_RST;
      regs.inv_focal_y <= INV_FOCAL_Y_RST;
      regs.mm_per_unit <= MM_PER_UNIT_RST;
      regs.max_depth   <= MAX_DEPTH_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_CENTER_X:    regs.center_x    <= cfg.wdata[CENTER_W-1:0];
        REG_CENTER_Y:    regs.center_y    <= cfg.wdata[CENTER_W-1:0];
        REG_INV_FOCAL_X: regs.inv_focal_x <= cfg.wdata[INV_W-1:0];
        REG_INV_FOCAL_Y: regs.inv_focal_y <= cfg.wdata[INV_W-1:0];
        REG_MM_PER_UNIT: regs.mm_per_unit <= cfg.wdata[SCALE_W-1:0];
        REG_MAX_DEPTH:   regs.max_depth   <= cfg.wdata[MAXD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/dpd_pipe.sv
`default_nettype none

module dpd_pipe import dpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       regs,
  dpd_pix_if.sink    pixel,
  dpd_pt_if.source   point
);

  // Stage occupancy and per-stage ready
  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  assign r4 = !v4 || point.ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign pixel.ready = r1;

  // ---------------- stage 1: depth scale product, pixel offsets
  logic [COL_W-1:0]        col_sat;
  logic [DEPTH_W-1:0]      raw1;
  logic [RAWPROD_W-1:0]    prod1;
  logic signed [OFS_W-1:0] dx1, dy1;
  rgb_t                    rgb1;
  logic                    fe1;

  // Clamp the column to the image width
  assign col_sat = (int'(pixel.data.pixel_col) > MAX_COLS - 1) ?
                   COL_W'(MAX_COLS - 1) : pixel.data.pixel_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      raw1  <= pixel.data.depth_raw;
      prod1 <= RAWPROD_W'(pixel.data.depth_raw) * RAWPROD_W'(regs.mm_per_unit);
      dx1   <= $signed({1'b0, col_sat, FRAC_PIX'(0)}) - $signed({1'b0, regs.center_x});
      dy1   <= $signed({1'b0, pixel.data.pixel_row, FRAC_PIX'(0)})
               - $signed({1'b0, regs.center_y});
      rgb1  <= '{red: pixel.data.red_in, green: pixel.data.green_in,
                 blue: pixel.data.blue_in};
      fe1   <= pixel.data.frame_end_in;
    end
  end

  // ---------------- stage 2: distance, cutoff, offset * z
  logic [DIST_W-1:0]      z_full;
  logic                   keep2;
  logic [DEPTH_W-1:0]     z2;
  logic signed [OZ_W-1:0] mx2, my2;
  rgb_t                   rgb2;
  logic                   fe2;

  assign z_full = prod1[RAWPROD_W-1:SCALE_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      keep2 <= (raw1 != '0) && (z_full <= DIST_W'(regs.max_depth));
      z2    <= z_full[DEPTH_W-1:0];
      mx2   <= OZ_W'(dx1 * $signed({1'b0, z_full[DEPTH_W-1:0]}));
      my2   <= OZ_W'(dy1 * $signed({1'b0, z_full[DEPTH_W-1:0]}));
      rgb2  <= rgb1;
      fe2   <= fe1;
    end
  end

  // ---------------- stage 3: times reciprocal focal length (Q.30 mm)
  logic                    keep3;
  logic [DEPTH_W-1:0]      z3;
  logic signed [LAT_W-1:0] px3, py3;
  rgb_t                    rgb3;
  logic                    fe3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (r3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      keep3 <= keep2;
      z3    <= z2;
      px3   <= LAT_W'(mx2 * $signed({1'b0, regs.inv_focal_x}));
      py3   <= LAT_W'(my2 * $signed({1'b0, regs.inv_focal_y}));
      rgb3  <= rgb2;
      fe3   <= fe2;
    end
  end

  // ---------------- stage 4: round half up to Q.4, output register
  // |product| < 2^56, so the rounded value always fits in 32 bits.
  logic signed [LAT_W-1:0] rx, ry;
  point_t                  out4;

  assign rx = px3 + (LAT_W'(1) <<< (ROUND_SHIFT - 1));
  assign ry = py3 + (LAT_W'(1) <<< (ROUND_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (r4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      out4.point_valid   <= keep3;
      out4.point_x       <= keep3 ? rx[ROUND_SHIFT+COORD_W-1:ROUND_SHIFT] : '0;
      out4.point_y       <= keep3 ? ry[ROUND_SHIFT+COORD_W-1:ROUND_SHIFT] : '0;
      out4.point_z       <= keep3 ? z3 : '0;
      out4.red_out       <= keep3 ? rgb3.red : '0;
      out4.green_out     <= keep3 ? rgb3.green : '0;
      out4.blue_out      <= keep3 ? rgb3.blue : '0;
      out4.frame_end_out <= fe3;
    end
  end

  assign point.valid = v4;
  assign point.data  = out4;

  // ---------------- checks
  a_drop_zeroed: assert property (@(posedge clk) disable iff (rst)
    v4 && !out4.point_valid |-> out4.point_x == '0 && out4.point_y == '0 &&
                                out4.point_z == '0 && out4.red_out == '0)
    else $error("dropped point carries nonzero payload");

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> v1 && v2 && v3 && v4)
    else $error("input stalled with a bubble in the pipeline");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !r2 |=> v1)
    else $error("stage 1 transaction lost under stall");

  a_stage3_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !r4 |=> v3 && $stable(px3))
    else $error("stage 3 transaction changed under stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !v1 && !v2 && !v3 && !v4)
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

### sv/depth_pixel_deprojection_top.sv
`default_nettype none

// Channel  Direction  Transaction
// -------  ---------  -----------------------------------------------
// pixel    in         column, row, raw depth, RGB, frame-end mark
// point    out        valid flag, x/y (Q27.4 mm), z (mm), RGB, frame-end
// cfg      in         register index and write data
//
// Four register stages: depth*scale and offsets, cutoff and offset*z,
// times reciprocal focal length, rounding into the output register.
// One pixel per clock unless the point output is held back.
// Synchronous reset empties the pipeline and loads the default intrinsics.
// Each stage advances when it is empty or the next one can take its
// transaction, so bubbles fill in while the output is held.
// Config writes never stall; cfg.ready is always high.

module depth_pixel_deprojection_top import dpd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  dpd_pix_if.sink  pixel,
  dpd_pt_if.source point,
  dpd_cfg_if.sink  cfg
);

  cfg_t regs;

  dpd_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  dpd_pipe u_pipe (
    .clk   (clk),
    .rst   (rst),
    .regs  (regs),
    .pixel (pixel),
    .point (point)
  );

endmodule

`default_nettype wire

### dv/depth_pixel_deprojection_top_test.sv
`timescale 1ns / 100ps

module depth_pixel_deprojection_top_test import dpd_pkg::*; ();

  localparam int          LATENCY       = 4;
  localparam int          SETTLE_CYCLES = LATENCY + 4;
  localparam int          RAND_PHASES   = 8;
  localparam int          PHASE_PIXELS  = 181;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int          MAX_REPORTS   = 10;

  // Indexes outside the register map; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam longint COORD_MAX = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  logic clk;
  logic rst;

  dpd_pix_if pix ();
  dpd_pt_if  pnt ();
  dpd_cfg_if cfg ();

  depth_pixel_deprojection_top uut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pix),
    .point (pnt),
    .cfg   (cfg)
  );

  // Shadow copy of the intrinsics as the block should hold them
  cfg_t intrinsics;

  pixel_t pixel_q[$];
  point_t point_expect_q[$];

  int unsigned queued_cnt;
  int unsigned accepted_cnt;
  int unsigned checked_cnt;
  int unsigned kept_cnt;
  int unsigned frame_end_cnt;
  int unsigned write_cnt;
  int unsigned setting_cnt;
  int unsigned mismatch_cnt;
  int unsigned error_cnt;
  int unsigned cycle_cnt;

  logic        pix_taken;
  int unsigned send_gap;
  int unsigned stall_left;
  logic        calm;
  int unsigned stretch_left;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Lateral coordinate: ((pix<<6) - center) * z * inv, Q.30 rounded half up to Q.4
  function automatic logic signed [COORD_W-1:0] lateral_mm(longint pix_idx, longint center,
                                                          longint z, longint inv);
    longint prod;
    longint q;
    prod = ((pix_idx << FRAC_PIX) - center) * z * inv;
    q = (prod + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (q > COORD_MAX) q = COORD_MAX;
    if (q < COORD_MIN) q = COORD_MIN;
    return q[COORD_W-1:0];
  endfunction

  // Expected point for one pixel under the given intrinsics
  function automatic point_t deproject(pixel_t px, cfg_t c);
    point_t           r;
    longint unsigned  z_full;
    logic [COL_W-1:0] col;
    r = '0;
    r.frame_end_out = px.frame_end_in;
    z_full = (longint'(px.depth_raw) * longint'(c.mm_per_unit)) >> SCALE_FRAC;
    if (px.depth_raw == '0 || z_full > longint'(c.max_depth)) return r;
    col = px.pixel_col;
    if (int'(col) > MAX_COLS - 1) col = COL_W'(MAX_COLS - 1);
    r.point_valid = 1'b1;
    r.point_x     = lateral_mm(longint'(col), longint'(c.center_x), longint'(z_full),
                               longint'(c.inv_focal_x));
    r.point_y     = lateral_mm(longint'(px.pixel_row), longint'(c.center_y), longint'(z_full),
                               longint'(c.inv_focal_y));
    r.point_z     = z_full[DEPTH_W-1:0];
    r.red_out     = px.red_in;
    r.green_out   = px.green_in;
    r.blue_out    = px.blue_in;
    return r;
  endfunction

  function automatic pixel_t make_pixel(int col, int row, int raw, int red, int green,
                                        int blue, int fe);
    pixel_t p;
    p.pixel_col    = COL_W'(col);
    p.pixel_row    = ROW_W'(row);
    p.depth_raw    = DEPTH_W'(raw);
    p.red_in       = COLOR_W'(red);
    p.green_in     = COLOR_W'(green);
    p.blue_in      = COLOR_W'(blue);
    p.frame_end_in = fe[0];
    return p;
  endfunction

  // Random pixel; depth mostly lands around the cutoff for the current setting
  function automatic pixel_t random_pixel();
    pixel_t          p;
    longint unsigned lim;
    int unsigned     sel;
    p   = make_pixel($urandom_range(0, 1023), $urandom_range(0, 1023), 0,
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     ($urandom_range(0, 99) < 6) ? 1 : 0);
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      p.depth_raw = '0;
    end else if (sel < 16) begin
      p.depth_raw = DEPTH_W'($urandom_range(0, 65535));
    end else if (sel < 20) begin
      p.depth_raw = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd1;
    end else begin
      if (intrinsics.mm_per_unit == '0) lim = 65535;
      else lim = ((longint'(intrinsics.max_depth) + 1) << SCALE_FRAC) /
                 longint'(intrinsics.mm_per_unit);
      lim = lim + lim / 8 + 2;
      if (lim > 65535) lim = 65535;
      p.depth_raw = DEPTH_W'($urandom_range(1, int'(lim)));
    end
    return p;
  endfunction

  // Gap length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Register value: extremes, near reset, or anything; upper bits random to probe masking
  function automatic logic [CFG_DATA_W-1:0] random_reg(int width, int unsigned rst_val);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] v;
    mask = CFG_DATA_W'((longint'(1) << width) - 1);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = mask;
      2, 3: v = CFG_DATA_W'(rst_val + $urandom_range(0, 63) - 32);
      default: v = CFG_DATA_W'($urandom);
    endcase
    return (CFG_DATA_W'($urandom) & ~mask) | (v & mask);
  endfunction

  task automatic check_field(string fname, logic [31:0] e, logic [31:0] g);
    if (e !== g) begin
      mismatch_cnt++;
      error_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("mismatch on point %0d, %s: expected 0x%08h, got 0x%08h",
                 checked_cnt, fname, e, g);
    end
  endtask

  // Register write over the config channel; shadow copy follows at the handshake
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    write_cnt++;
    case (idx)
      REG_CENTER_X:    intrinsics.center_x    = val[CENTER_W-1:0];
      REG_CENTER_Y:    intrinsics.center_y    = val[CENTER_W-1:0];
      REG_INV_FOCAL_X: intrinsics.inv_focal_x = val[INV_W-1:0];
      REG_INV_FOCAL_Y: intrinsics.inv_focal_y = val[INV_W-1:0];
      REG_MM_PER_UNIT: intrinsics.mm_per_unit = val[SCALE_W-1:0];
      REG_MAX_DEPTH:   intrinsics.max_depth   = val[MAXD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg.valid <= 1'b0;
    setting_cnt++;
  endtask

  task automatic queue_pixel(pixel_t p);
    pixel_q.push_back(p);
    queued_cnt++;
  endtask

  // Wait until every queued pixel has come back as a point, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    while (accepted_cnt != queued_cnt || point_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: next pixel once the current transaction is taken, with random gaps
  always @(negedge clk) begin
    if (!rst && (!pix.valid || pix_taken)) begin
      pix_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        pix.valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        pix.data  <= pixel_q.pop_front();
        pix.valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // Output back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      pnt.ready <= 1'b0;
    end else begin
      pnt.ready <= 1'b1;
      if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  // Monitor: check the point transaction, then record the pixel transaction
  always @(posedge clk) begin
    point_t exp_pt;
    if (!rst && pnt.valid && pnt.ready) begin
      if (point_expect_q.size() == 0) begin
        mismatch_cnt++;
        error_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("point with no pixel pending: %h", pnt.data);
      end else begin
        exp_pt = point_expect_q.pop_front();
        check_field("point_valid",   32'(exp_pt.point_valid),   32'(pnt.data.point_valid));
        check_field("point_x",       32'(exp_pt.point_x),       32'(pnt.data.point_x));
        check_field("point_y",       32'(exp_pt.point_y),       32'(pnt.data.point_y));
        check_field("point_z",       32'(exp_pt.point_z),       32'(pnt.data.point_z));
        check_field("red_out",       32'(exp_pt.red_out),       32'(pnt.data.red_out));
        check_field("green_out",     32'(exp_pt.green_out),     32'(pnt.data.green_out));
        check_field("blue_out",      32'(exp_pt.blue_out),      32'(pnt.data.blue_out));
        check_field("frame_end_out", 32'(exp_pt.frame_end_out), 32'(pnt.data.frame_end_out));
        if (exp_pt.point_valid) kept_cnt++;
        if (exp_pt.frame_end_out) frame_end_cnt++;
        checked_cnt++;
      end
    end
    if (!rst && pix.valid && pix.ready) begin
      point_expect_q.push_back(deproject(pix.data, intrinsics));
      pix_taken = 1'b1;
      accepted_cnt++;
    end
    // alternate stretches with and without idling
    if (stretch_left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      stretch_left = $urandom_range(30, 300);
    end else begin
      stretch_left--;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points still pending", cycle_cnt,
               point_expect_q.size());
      $display("FAIL depth_pixel_deprojection_top");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    pix.valid    = 1'b0;
    pix.data     = '0;
    pnt.ready    = 1'b0;
    cfg.valid    = 1'b0;
    cfg.index    = '0;
    cfg.wdata    = '0;
    pix_taken    = 1'b0;
    send_gap     = 0;
    stall_left   = 0;
    calm         = 1'b0;
    stretch_left = 0;
    queued_cnt   = 0;
    accepted_cnt = 0;
    checked_cnt  = 0;
    kept_cnt     = 0;
    frame_end_cnt = 0;
    write_cnt    = 0;
    setting_cnt  = 1;
    mismatch_cnt = 0;
    error_cnt    = 0;
    cycle_cnt    = 0;
    intrinsics.center_x    = CENTER_X_RST;
    intrinsics.center_y    = CENTER_Y_RST;
    intrinsics.inv_focal_x = INV_FOCAL_X_RST;
    intrinsics.inv_focal_y = INV_FOCAL_Y_RST;
    intrinsics.mm_per_unit = MM_PER_UNIT_RST;
    intrinsics.max_depth   = MAX_DEPTH_RST;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset intrinsics: 1 mm per unit, 1000 mm cutoff
    queue_pixel(make_pixel(0,    0,    0,     255, 255, 255, 1));  // no depth, frame end kept
    queue_pixel(make_pixel(0,    0,    1,     0,   0,   0,   0));
    queue_pixel(make_pixel(1023, 1023, 1000,  255, 0,   255, 0));  // right at the cutoff
    queue_pixel(make_pixel(1023, 1023, 1001,  1,   2,   3,   1));  // just past the cutoff
    queue_pixel(make_pixel(512,  512,  65535, 9,   9,   9,   0));
    queue_pixel(make_pixel(314,  231,  500,   85,  170, 85,  0));  // near principal point
    queue_pixel(make_pixel(1023, 0,    999,   255, 255, 255, 1));
    queue_pixel(make_pixel(0,    1023, 0,     0,   0,   0,   0));
    drain();

    // Tiny scale: nonzero depth rounding down to zero distance is still a point
    write_reg(REG_MM_PER_UNIT, 24'd1);
    write_reg(REG_MAX_DEPTH,   24'hFF0000);
    write_reg(REG_UNMAPPED_LO, 24'h123456);
    write_reg(REG_UNMAPPED_HI, 24'hFFFFFF);
    end_writes();
    queue_pixel(make_pixel(100,  900,  1,     10,  20,  30,  0));
    queue_pixel(make_pixel(1023, 0,    65535, 255, 0,   0,   1));
    queue_pixel(make_pixel(5,    5,    0,     1,   1,   1,   0));
    drain();

    // Extreme intrinsics; distance beyond 16 bits must drop the point
    write_reg(REG_CENTER_X,    24'h000000);
    write_reg(REG_CENTER_Y,    24'hA5FFFF);
    write_reg(REG_INV_FOCAL_X, 24'hFFFFFF);
    write_reg(REG_INV_FOCAL_Y, 24'hFFFFFF);
    write_reg(REG_MM_PER_UNIT, 24'hFFFFFF);
    write_reg(REG_MAX_DEPTH,   24'h00FFFF);
    end_writes();
    queue_pixel(make_pixel(1023, 0,    256,   255, 255, 255, 0));  // largest |x|, |y|
    queue_pixel(make_pixel(1023, 1023, 257,   7,   7,   7,   1));
    queue_pixel(make_pixel(0,    0,    65535, 0,   255, 0,   0));
    queue_pixel(make_pixel(512,  0,    1,     128, 64,  32,  1));
    queue_pixel(make_pixel(0,    1023, 255,   0,   0,   255, 0));
    drain();

    // Random phases: all-high, all-low, reset values, then random settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_CENTER_X,    24'hFFFFFF);
          write_reg(REG_CENTER_Y,    24'h00FFFF);
          write_reg(REG_INV_FOCAL_X, 24'hFFFFFF);
          write_reg(REG_INV_FOCAL_Y, 24'hFFFFFF);
          write_reg(REG_MM_PER_UNIT, 24'hFFFFFF);
          write_reg(REG_MAX_DEPTH,   24'hFFFFFF);
        end
        1: begin
          write_reg(REG_CENTER_X,    24'hFF0000);
          write_reg(REG_CENTER_Y,    24'h000000);
          write_reg(REG_INV_FOCAL_X, 24'h000000);
          write_reg(REG_INV_FOCAL_Y, 24'h000000);
          write_reg(REG_MM_PER_UNIT, 24'h000000);
          write_reg(REG_MAX_DEPTH,   24'h000000);
        end
        2: begin
          write_reg(REG_CENTER_X,    CFG_DATA_W'(CENTER_X_RST));
          write_reg(REG_CENTER_Y,    CFG_DATA_W'(CENTER_Y_RST));
          write_reg(REG_INV_FOCAL_X, CFG_DATA_W'(INV_FOCAL_X_RST));
          write_reg(REG_INV_FOCAL_Y, CFG_DATA_W'(INV_FOCAL_Y_RST));
          write_reg(REG_MM_PER_UNIT, CFG_DATA_W'(MM_PER_UNIT_RST));
          write_reg(REG_MAX_DEPTH,   CFG_DATA_W'(MAX_DEPTH_RST));
        end
        default: begin
          write_reg(REG_CENTER_X,    random_reg(CENTER_W, CENTER_X_RST));
          write_reg(REG_CENTER_Y,    random_reg(CENTER_W, CENTER_Y_RST));
          write_reg(REG_INV_FOCAL_X, random_reg(INV_W, INV_FOCAL_X_RST));
          write_reg(REG_INV_FOCAL_Y, random_reg(INV_W, INV_FOCAL_Y_RST));
          write_reg(REG_MM_PER_UNIT, random_reg(SCALE_W, MM_PER_UNIT_RST));
          write_reg(REG_MAX_DEPTH,   random_reg(MAXD_W, MAX_DEPTH_RST));
          if ($urandom_range(0, 1) == 1)
            write_reg(($urandom_range(0, 1) == 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO,
                      CFG_DATA_W'($urandom));
        end
      endcase
      end_writes();
      for (int i = 0; i < PHASE_PIXELS; i++) queue_pixel(random_pixel());
      drain();
    end

    if (point_expect_q.size() != 0) error_cnt++;
    $display("%0d pixels sent, %0d points checked (%0d kept, %0d frame ends)",
             queued_cnt, checked_cnt, kept_cnt, frame_end_cnt);
    $display("%0d register writes over %0d intrinsic settings, %0d mismatches",
             write_cnt, setting_cnt, mismatch_cnt);
    if (error_cnt == 0)
      $display("PASS depth_pixel_deprojection_top");
    else
      $display("FAIL depth_pixel_deprojection_top");
    $finish;
  end

endmodule
